[sv/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, codes, types and helpers for the k-way sorted merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int LISTS     = 8;
  localparam int BUF_DEPTH = 8;

  localparam int LIST_W    = 3;
  localparam int VAL_W     = 32;
  localparam int CNT_W     = 4;
  localparam int KIND_W    = 2;
  localparam int LIDX_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int PTR_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
  localparam int MEM_DEPTH = LISTS * BUF_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [CNT_W-1:0] LIST_COUNT_RESET = CNT_W'(8);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OVER  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic clear;
    logic cand_valid;
  } scan_ctl_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(BUF_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [LIDX_W-1:0] lidx,
                                                 input logic [PTR_W-1:0] ptr);
    return MEM_AW'(lidx) * MEM_AW'(BUF_DEPTH) + MEM_AW'(ptr);
  endfunction

endpackage

[sv/kwm_buf_mem.sv]
// ----------------------------------------------------------------------------
// kwm_buf_mem
// Storage for all list buffers: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kwm_buf_mem
  import kwm_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [MEM_AW-1:0] waddr,
  input  logic [VAL_W-1:0]  wdata,
  input  logic [MEM_AW-1:0] raddr,
  output logic [VAL_W-1:0]  rdata
);

  logic [VAL_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/kwm_min_scan.sv]
// ----------------------------------------------------------------------------
// kwm_min_scan
// Shared signed comparator that keeps the smallest head seen during a scan.
// ----------------------------------------------------------------------------
module kwm_min_scan
  import kwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  scan_ctl_t               ctl,
  input  logic [LIDX_W-1:0]       cand_idx,
  input  logic [VAL_W-1:0]        cand_value,
  output logic [LIDX_W-1:0]       best_idx,
  output logic signed [VAL_W-1:0] best_value
);

  logic have;
  logic take;

  // Strict less-than keeps the lowest list index on ties, since lists scan upward.
  assign take = ctl.cand_valid && (!have || ($signed(cand_value) < best_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      best_idx   <= cand_idx;
      best_value <= $signed(cand_value);
    end
  end

endmodule

[sv/k_way_sorted_merge_top.sv]
// ----------------------------------------------------------------------------
// k_way_sorted_merge_top
// Merges up to LISTS ascending signed streams into one ascending stream.
// A beat is checked in S_CHECK; a rejected beat gets its flag once the output is free,
// and the next can follow. An accepted beat stays busy through S_EVAL and, per element,
// S_SCAN over the lists in use, S_TAIL and S_EMIT; a result waiting on the output stalls it.
// Reset clears pointers, fill counts and ended marks and sets list_count to 8.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_top
  import kwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [LIST_W-1:0]        list_id,
  input  logic signed [VAL_W-1:0]  value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        kind,
  output logic signed [VAL_W-1:0]  merged_value,
  output logic [LIST_W-1:0]        source_list,
  output logic                     last_of_run,
  output logic                     merge_done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_SCAN,
    S_TAIL,
    S_EMIT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  list_count;
  logic              act_r;
  logic [LIST_W-1:0] id_r;
  logic [VAL_W-1:0]  val_r;

  logic [PTR_W-1:0]  rd_ptr [LISTS];
  logic [PTR_W-1:0]  wr_ptr [LISTS];
  logic [FILL_W-1:0] fill   [LISTS];
  logic [LISTS-1:0]  ended;

  logic [LIDX_W-1:0] sc;
  logic              cand_v;
  logic [LIDX_W-1:0] cand_idx;

  logic [CNT_W-1:0]  n_use;
  logic [LISTS-1:0]  in_use;
  logic [LISTS-1:0]  ne;
  logic [LISTS-1:0]  ne_after;
  logic [LISTS-1:0]  pop_mask;
  logic [LIDX_W-1:0] sel;
  logic              bad;
  logic              over;
  logic              ready_now;
  logic              any_now;
  logic              complete_now;
  logic              ready_after;
  logic              any_after;
  logic              complete_after;
  logic              last_elem;
  logic              sc_last;
  logic              out_free;
  logic              emit_beat;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;
  logic [VAL_W-1:0]  mem_rdata;

  scan_ctl_t                ctl;
  logic [LIDX_W-1:0]        best_idx;
  logic signed [VAL_W-1:0]  best_value;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (list_count == '0) begin
      n_use = CNT_W'(1);
    end else if (list_count > CNT_W'(LISTS)) begin
      n_use = CNT_W'(LISTS);
    end else begin
      n_use = list_count;
    end
    for (int i = 0; i < LISTS; i++) begin
      in_use[i] = CNT_W'(i) < n_use;
      ne[i]     = fill[i] != '0;
    end
  end

  always_comb begin
    case (state)
      S_CHECK: sel = LIDX_W'(id_r);
      S_SCAN:  sel = sc;
      default: sel = best_idx;
    endcase
  end

  always_comb begin
    bad  = ({1'b0, id_r} >= n_use) || ended[sel];
    over = (act_r == ACT_PUSH) && (fill[sel] == FILL_W'(BUF_DEPTH));

    ready_now    = &(ne | ended | ~in_use);
    any_now      = |(ne & in_use);
    complete_now = &((ended & ~ne) | ~in_use);

    pop_mask       = (fill[sel] == FILL_W'(1)) ? (LISTS'(1) << best_idx) : '0;
    ne_after       = ne & ~pop_mask;
    ready_after    = &(ne_after | ended | ~in_use);
    any_after      = |(ne_after & in_use);
    complete_after = &((ended & ~ne_after) | ~in_use);
    last_elem      = !(ready_after && any_after);

    sc_last = (CNT_W'(sc) == n_use - CNT_W'(1));

    emit_beat = out_free &&
                (((state == S_CHECK) && (bad || over)) ||
                 ((state == S_EVAL) && !(ready_now && any_now) && complete_now) ||
                 (state == S_EMIT));
  end

  assign mem_we    = (state == S_CHECK) && !bad && !over && (act_r == ACT_PUSH);
  assign mem_waddr = mem_addr(sel, wr_ptr[sel]);
  assign mem_raddr = mem_addr(sel, rd_ptr[sel]);

  assign ctl.clear      = (state == S_EVAL) && ready_now && any_now;
  assign ctl.cand_valid = cand_v;

  kwm_buf_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (val_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kwm_min_scan u_min (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cand_idx   (cand_idx),
    .cand_value (mem_rdata),
    .best_idx   (best_idx),
    .best_value (best_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cand_v     <= 1'b0;
      ended      <= '0;
      list_count <= LIST_COUNT_RESET;
      for (int i = 0; i < LISTS; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        fill[i]   <= '0;
      end
    end else begin
      out_valid <= emit_beat || (out_valid && !out_ready);
      cand_v    <= (state == S_SCAN) && ne[sc];
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            list_count <= cfg_data;
          end
          if (in_valid) begin
            act_r <= action;
            id_r  <= list_id;
            val_r <= value;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (bad || over) begin
            if (out_free) begin
              kind         <= bad ? KIND_BAD : KIND_OVER;
              merged_value <= '0;
              source_list  <= id_r;
              last_of_run  <= 1'b1;
              merge_done   <= 1'b0;
              state        <= S_IDLE;
            end
          end else if (act_r == ACT_PUSH) begin
            wr_ptr[sel] <= ptr_inc(wr_ptr[sel]);
            fill[sel]   <= fill[sel] + FILL_W'(1);
            state       <= S_EVAL;
          end else begin
            ended[sel] <= 1'b1;
            state      <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (ready_now && any_now) begin
            sc    <= '0;
            state <= S_SCAN;
          end else if (complete_now) begin
            if (out_free) begin
              kind         <= KIND_EMPTY;
              merged_value <= '0;
              source_list  <= id_r;
              last_of_run  <= 1'b1;
              merge_done   <= 1'b1;
              ended        <= '0;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          cand_idx <= sc;
          if (sc_last) begin
            state <= S_TAIL;
          end else begin
            sc <= sc + LIDX_W'(1);
          end
        end
        S_TAIL: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            kind         <= KIND_ELEM;
            merged_value <= best_value;
            source_list  <= LIST_W'(best_idx);
            last_of_run  <= last_elem;
            merge_done   <= complete_after;
            rd_ptr[sel]  <= ptr_inc(rd_ptr[sel]);
            fill[sel]    <= fill[sel] - FILL_W'(1);
            if (complete_after) begin
              ended <= '0;
            end
            state <= last_elem ? S_IDLE : S_EVAL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tb_k_way_sorted_merge_top.sv]
// ----------------------------------------------------------------------------
// tb_k_way_sorted_merge_top
// Self-checking bench for the k-way sorted merge block. An in-bench predictor
// tracks the list buffers, ended marks and list count, and queues the merged
// beats each accepted input should cause. Directed checks cover ordering,
// ties, rejects, overflow and list count extremes. Random merges follow, with
// noise, idle gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_merge_top;
  import kwm_pkg::*;

  localparam int     IDLE_PCT       = 9;
  localparam int     NOISE_PCT      = 15;
  localparam int     RANDOM_ITEMS   = 230;
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     STALL_CYCLES   = 400;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint VALUE_MAX      = 64'sd2147483647;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [VAL_W-1:0]  val;
    logic [LIST_W-1:0]        src;
    logic                     last;
    logic                     done;
  } merge_beat_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     action;
  logic [LIST_W-1:0]        list_id;
  logic signed [VAL_W-1:0]  value;
  logic                     out_valid;
  logic                     out_ready;
  logic [KIND_W-1:0]        kind;
  logic signed [VAL_W-1:0]  merged_value;
  logic [LIST_W-1:0]        source_list;
  logic                     last_of_run;
  logic                     merge_done;

  logic signed [VAL_W-1:0]  pred_buf [LISTS][BUF_DEPTH];
  logic [PTR_W-1:0]         pred_rd [LISTS];
  logic [PTR_W-1:0]         pred_wr [LISTS];
  logic [FILL_W-1:0]        pred_fill [LISTS];
  logic                     pred_ended [LISTS];
  logic [CNT_W-1:0]         pred_count;
  bit                       merge_closed;

  merge_beat_t              expected_merge_out [$];
  longint                   gen_last [LISTS];
  int                       gen_left [LISTS];
  int                       items_sent;
  int                       error_count;
  int                       idle_cycles;
  bit                       quiet;
  bit                       hold_req;

  k_way_sorted_merge_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .list_id      (list_id),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .merged_value (merged_value),
    .source_list  (source_list),
    .last_of_run  (last_of_run),
    .merge_done   (merge_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int lists_active();
    if (pred_count == 0) return 1;
    if (pred_count > LISTS) return LISTS;
    return int'(pred_count);
  endfunction

  task automatic merge_predict(input logic act, input logic [LIST_W-1:0] id,
                               input logic signed [VAL_W-1:0] val);
    int n;
    int best;
    int cnt;
    bit rdy;
    bit complete;
    logic signed [VAL_W-1:0] best_val;
    merge_beat_t run [$];
    n = lists_active();
    cnt = 0;
    best_val = '0;
    if (int'(id) >= n || pred_ended[id]) begin
      expected_merge_out.push_back('{KIND_BAD, '0, id, 1'b1, 1'b0});
      return;
    end
    if (act == ACT_PUSH) begin
      if (pred_fill[id] >= BUF_DEPTH) begin
        expected_merge_out.push_back('{KIND_OVER, '0, id, 1'b1, 1'b0});
        return;
      end
      pred_buf[id][pred_wr[id]] = val;
      pred_wr[id] = PTR_W'((int'(pred_wr[id]) + 1) % BUF_DEPTH);
      pred_fill[id] = pred_fill[id] + 1'b1;
    end else begin
      pred_ended[id] = 1'b1;
    end
    forever begin
      rdy = 1'b1;
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (pred_fill[i] == 0) begin
          if (!pred_ended[i]) rdy = 1'b0;
        end else if (best < 0 || pred_buf[i][pred_rd[i]] < best_val) begin
          best = i;
          best_val = pred_buf[i][pred_rd[i]];
        end
      end
      if (!rdy || best < 0 || cnt >= 64) break;
      run.push_back('{KIND_ELEM, best_val, LIST_W'(best), 1'b0, 1'b0});
      pred_rd[best] = PTR_W'((int'(pred_rd[best]) + 1) % BUF_DEPTH);
      pred_fill[best] = pred_fill[best] - 1'b1;
      cnt++;
    end
    complete = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!pred_ended[i] || pred_fill[i] != 0) complete = 1'b0;
    end
    if (complete) begin
      merge_closed = 1'b1;
      for (int i = 0; i < LISTS; i++) pred_ended[i] = 1'b0;
      if (cnt == 0) begin
        expected_merge_out.push_back('{KIND_EMPTY, '0, id, 1'b1, 1'b1});
        return;
      end
      run[cnt-1].done = 1'b1;
    end
    if (cnt > 0) run[cnt-1].last = 1'b1;
    foreach (run[i]) expected_merge_out.push_back(run[i]);
  endtask

  task automatic send_beat(input logic act, input logic [LIST_W-1:0] id,
                           input logic signed [VAL_W-1:0] val);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    list_id  = id;
    value    = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    merge_predict(act, id, val);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_merge_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_list_count(input logic [CNT_W-1:0] count);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred_count = count;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_merge(input int min_len, input int max_len, input bit narrow,
                           input int noise_pct);
    int n;
    int c;
    int cands [$];
    longint step;
    longint nxt;
    n = lists_active();
    merge_closed = 1'b0;
    for (int i = 0; i < LISTS; i++) begin
      gen_left[i] = $urandom_range(min_len, max_len);
      if (narrow) gen_last[i] = longint'($urandom_range(0, 15)) - 8;
      else gen_last[i] = longint'($signed($urandom));
    end
    while (!merge_closed) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_beat(1'($urandom_range(0, 1)), LIST_W'($urandom_range(0, LISTS - 1)),
                  VAL_W'($urandom));
      end else begin
        cands.delete();
        for (int i = 0; i < n; i++) begin
          if (!pred_ended[i] && pred_fill[i] < BUF_DEPTH) cands.push_back(i);
        end
        if (cands.size() == 0) break;
        c = cands[$urandom_range(0, cands.size() - 1)];
        if (gen_left[c] > 0 && gen_last[c] < VALUE_MAX) begin
          if (narrow) step = longint'($urandom_range(0, 2));
          else if ($urandom_range(0, 9) == 0) step = longint'($urandom_range(0, 32'h7fffffff));
          else step = longint'($urandom_range(0, 1000));
          nxt = gen_last[c] + step;
          if (nxt > VALUE_MAX) nxt = VALUE_MAX;
          gen_last[c] = nxt;
          gen_left[c]--;
          send_beat(ACT_PUSH, LIST_W'(c), VAL_W'(nxt));
        end else begin
          send_beat(ACT_END, LIST_W'(c), VAL_W'($urandom));
        end
      end
    end
  endtask

  task automatic test_reset_count();
    // List 7 is only in use while the reset count of eight holds.
    send_beat(ACT_PUSH, 3'd7, -32'sd1);
  endtask

  task automatic test_merge_order();
    write_list_count(4'd2);
    send_beat(ACT_PUSH, 3'd0, 32'sh80000000);
    send_beat(ACT_PUSH, 3'd1, 32'sh7fffffff);
    send_beat(ACT_PUSH, 3'd0, 32'sd7);
    send_beat(ACT_PUSH, 3'd0, 32'sh7fffffff);
    send_beat(ACT_END, 3'd0, 32'shffffffff);
    send_beat(ACT_END, 3'd1, 32'sd0);
  endtask

  task automatic test_rejects();
    send_beat(ACT_PUSH, 3'd2, 32'sd1);
    send_beat(ACT_END, 3'd0, 32'sd0);
    send_beat(ACT_END, 3'd0, 32'sd0);
    send_beat(ACT_PUSH, 3'd0, 32'sd3);
    send_beat(ACT_END, 3'd1, 32'sd0);
  endtask

  task automatic test_overflow();
    for (int k = 1; k <= BUF_DEPTH + 1; k++) send_beat(ACT_PUSH, 3'd1, VAL_W'(k));
    send_beat(ACT_END, 3'd0, 32'sd0);
    send_beat(ACT_END, 3'd1, 32'sd0);
  endtask

  task automatic test_count_extremes();
    write_list_count(4'd0);
    send_beat(ACT_PUSH, 3'd0, 32'sd5);
    send_beat(ACT_PUSH, 3'd1, 32'sd6);
    send_beat(ACT_END, 3'd0, 32'sd0);
    write_list_count(4'd15);
    send_beat(ACT_PUSH, 3'd7, 32'sh80000000);
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    write_list_count(4'd8);
    run_merge(0, 10, 1'b0, 0);
    write_list_count(4'd1);
    run_merge(4, 10, 1'b0, 0);
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    write_list_count(4'd2);
    hold_req = 1'b1;
    run_merge(12, 20, 1'b1, 0);
  endtask

  task automatic test_random_merges();
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) write_list_count(4'd0);
      else if (pick == 1) write_list_count(CNT_W'($urandom_range(9, 15)));
      else write_list_count(CNT_W'($urandom_range(1, 8)));
      repeat ($urandom_range(1, 3)) begin
        run_merge(0, 10, $urandom_range(0, 3) == 0, NOISE_PCT);
      end
    end
  endtask

  task automatic check_field(input string name, input longint exp_val,
                             input longint act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    merge_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_merge_out.size() == 0) begin
        $error("unexpected result beat: kind %0d value %0d list %0d", kind,
               merged_value, source_list);
        error_count++;
      end else begin
        want = expected_merge_out.pop_front();
        check_field("kind", want.kind, kind);
        check_field("merged_value", want.val, merged_value);
        check_field("source_list", want.src, source_list);
        check_field("last_of_run", want.last, last_of_run);
        check_field("merge_done", want.done, merge_done);
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("k_way_sorted_merge_top test failed");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_PUSH;
    list_id     = '0;
    value       = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    error_count = 0;
    pred_count  = LIST_COUNT_RESET;
    for (int i = 0; i < LISTS; i++) begin
      pred_rd[i]    = '0;
      pred_wr[i]    = '0;
      pred_fill[i]  = '0;
      pred_ended[i] = 1'b0;
      for (int j = 0; j < BUF_DEPTH; j++) pred_buf[i][j] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_count();
    test_merge_order();
    test_rejects();
    test_overflow();
    test_count_extremes();
    test_full_rate();
    test_output_stall();
    test_random_merges();

    wait_idle();
    if (error_count == 0 && expected_merge_out.size() == 0) begin
      $display("k_way_sorted_merge_top test passed");
    end else begin
      $display("k_way_sorted_merge_top test failed");
    end
    $finish;
  end

endmodule
